[src/assert_macros.svh]
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define RTC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

`define RTC_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`else

`define RTC_ASSERT(lbl, clk, rst, prop)

`define RTC_NEVER(lbl, clk, rst, expr)

`endif

`endif

[src/rtc_pkg.sv]
package rtc_pkg;

   localparam int FRAC_BITS = 16;
   localparam int MAX_STEPS = 256;

   localparam int DATA_W  = 32;
   localparam int INT_W   = 31;
   localparam int SPUD_W  = 7;
   localparam int STEP_W  = $clog2(MAX_STEPS + 1);
   localparam int CSR_IDX_W = 4;

   localparam int NPROD_W = INT_W + SPUD_W;
   localparam int NRAW_W  = NPROD_W - FRAC_BITS;

   localparam int DIV_CNT_W = $clog2(INT_W + 1);

   localparam int DIFF_W  = DATA_W + 1;
   localparam int PROD_W  = INT_W + 1 + DIFF_W;
   localparam int DELTA_W = PROD_W - FRAC_BITS;
   localparam int SUM_W   = DELTA_W + 1;

   localparam logic [CSR_IDX_W-1:0] REG_SATURATE_DEPTH = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_STEPS_PER_UNIT = CSR_IDX_W'(1);

   localparam logic [INT_W-1:0]  SATURATE_RESET = INT_W'(10 << FRAC_BITS);
   localparam logic [SPUD_W-1:0] STEPS_RESET    = SPUD_W'(20);

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

[src/rtc_if.sv]
interface rtc_req_if;
   import rtc_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] optical_depth;
   logic signed [DATA_W-1:0] cell_source;
   logic                     last_cell;
   modport source (output valid, optical_depth, cell_source, last_cell, input ready);
   modport sink (input valid, optical_depth, cell_source, last_cell, output ready);
endinterface

interface rtc_rsp_if;
   import rtc_pkg::*;
   logic             valid;
   logic             ready;
   logic [INT_W-1:0] intensity;
   logic             column_end;
   modport source (output valid, intensity, column_end, input ready);
   modport sink (input valid, intensity, column_end, output ready);
endinterface

interface rtc_csr_if;
   import rtc_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [DATA_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[src/rtc_div.sv]
module rtc_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rtc_pkg::INT_W-1:0]     dividend,
   input  logic [rtc_pkg::STEP_W-1:0]    divisor,
   output logic [rtc_pkg::INT_W-1:0]     quotient,
   output rtc_pkg::div_status_type       status
);
   import rtc_pkg::*;

   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic                 done_ff, done_in;
   logic [STEP_W-1:0]    rem_ff, rem_in;
   logic [INT_W-1:0]     quo_ff, quo_in;
   logic [STEP_W:0]      shifted;
   logic                 fits;

   // restoring division, one quotient bit per cycle
   assign shifted = {rem_ff, quo_ff[INT_W-1]};
   assign fits    = shifted >= {1'b0, divisor};

   always_comb begin
      count_in = count_ff;
      done_in  = 1'b0;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      if (start) begin
         count_in = DIV_CNT_W'(INT_W);
         rem_in   = '0;
         quo_in   = dividend;
      end else if (count_ff != '0) begin
         count_in = count_ff - 1'b1;
         done_in  = (count_ff == DIV_CNT_W'(1));
         rem_in   = fits ? STEP_W'(shifted - {1'b0, divisor}) : shifted[STEP_W-1:0];
         quo_in   = {quo_ff[INT_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = count_ff != '0;
   assign status.done = done_ff;

endmodule

[src/rtc_mac.sv]
module rtc_mac (
   input  logic                             clock,
   input  logic                             load,
   input  logic [rtc_pkg::INT_W-1:0]        dt,
   input  logic signed [rtc_pkg::DATA_W-1:0] src,
   input  logic [rtc_pkg::INT_W-1:0]        cur,
   output logic [rtc_pkg::INT_W-1:0]        nxt
);
   import rtc_pkg::*;

   logic signed [DIFF_W-1:0]  diff;
   logic signed [PROD_W-1:0]  prod_full;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [DELTA_W-1:0] delta;
   logic signed [SUM_W-1:0]   sum;

   assign diff      = $signed({src[DATA_W-1], src}) - $signed({{(DIFF_W-INT_W){1'b0}}, cur});
   assign prod_full = $signed({1'b0, dt}) * diff;
   assign prod_in   = load ? prod_full : prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // floor shift of the product, then add and clamp
   assign delta = $signed(prod_ff[PROD_W-1:FRAC_BITS]);
   assign sum   = $signed({delta[DELTA_W-1], delta}) + $signed({{(SUM_W-INT_W){1'b0}}, cur});

   always_comb begin
      if (sum[SUM_W-1]) begin
         nxt = '0;
      end else if (sum[SUM_W-2:INT_W] != '0) begin
         nxt = '1;
      end else begin
         nxt = sum[INT_W-1:0];
      end
   end

endmodule

[src/radiative_transfer_column_step_top.sv]
// channel | dir | payload                              | transfer
// req     | in  | optical_depth, cell_source, last_cell | valid && ready
// rsp     | out | intensity, column_end                | valid && ready
// csr     | in  | index, data                          | valid && ready, always ready
// a cell with depth zero or less, or above the saturation depth, goes from idle straight to done
// a stepped cell passes through n calc, start and the divider, then a multiply and an accumulate state per substep
// the substep loop runs through one multiplier whose product is registered
// reset is synchronous: intensity to zero, state, rsp valid and the csr registers to their reset values
// a new cell is taken while the last result still waits on rsp
`include "assert_macros.svh"

module radiative_transfer_column_step_top (
   input logic clock,
   input logic reset,
   rtc_req_if.sink   req,
   rtc_rsp_if.source rsp,
   rtc_csr_if.sink   csr
);
   import rtc_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_NCALC = 3'd1;
   localparam logic [2:0] S_START = 3'd2;
   localparam logic [2:0] S_DIV   = 3'd3;
   localparam logic [2:0] S_MUL   = 3'd4;
   localparam logic [2:0] S_ACC   = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0]               state_ff, state_in;
   logic [INT_W-1:0]         intensity_ff, intensity_in;
   logic [INT_W-1:0]         sat_ff, sat_in;
   logic [SPUD_W-1:0]        spud_ff, spud_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [INT_W-1:0]         rsp_int_ff, rsp_int_in;
   logic                     rsp_end_ff, rsp_end_in;
   logic [INT_W-1:0]         depth_ff, depth_in;
   logic signed [DATA_W-1:0] source_ff, source_in;
   logic                     last_ff, last_in;
   logic [STEP_W-1:0]        n_ff, n_in;
   logic [STEP_W-1:0]        steps_left_ff, steps_left_in;

   logic [NPROD_W-1:0]       nprod;
   logic [NRAW_W-1:0]        nraw;
   logic [STEP_W-1:0]        nclamp;
   logic                     out_free;
   logic                     div_start;
   logic [INT_W-1:0]         dt;
   div_status_type           div_st;
   logic                     mac_load;
   logic [INT_W-1:0]         mac_nxt;

   rtc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (depth_ff),
      .divisor  (n_ff),
      .quotient (dt),
      .status   (div_st)
   );

   rtc_mac u_mac (
      .clock (clock),
      .load  (mac_load),
      .dt    (dt),
      .src   (source_ff),
      .cur   (intensity_ff),
      .nxt   (mac_nxt)
   );

   assign nprod = depth_ff * spud_ff;
   assign nraw  = nprod[NPROD_W-1:FRAC_BITS];

   always_comb begin
      if (nraw == '0) begin
         nclamp = STEP_W'(1);
      end else if (nraw > NRAW_W'(MAX_STEPS)) begin
         nclamp = STEP_W'(MAX_STEPS);
      end else begin
         nclamp = nraw[STEP_W-1:0];
      end
   end

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign div_start = state_ff == S_START;
   assign mac_load  = state_ff == S_MUL;

   always_comb begin
      state_in      = state_ff;
      intensity_in  = intensity_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_int_in    = rsp_int_ff;
      rsp_end_in    = rsp_end_ff;
      depth_in      = depth_ff;
      source_in     = source_ff;
      last_in       = last_ff;
      n_in          = n_ff;
      steps_left_in = steps_left_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               depth_in  = req.optical_depth[INT_W-1:0];
               source_in = req.cell_source;
               last_in   = req.last_cell;
               if (req.optical_depth[DATA_W-1] || req.optical_depth == '0) begin
                  state_in = S_DONE;
               end else if (req.optical_depth[INT_W-1:0] > sat_ff) begin
                  intensity_in = req.cell_source[DATA_W-1] ? '0 : req.cell_source[INT_W-1:0];
                  state_in     = S_DONE;
               end else begin
                  state_in = S_NCALC;
               end
            end
         end
         S_NCALC: begin
            n_in     = nclamp;
            state_in = S_START;
         end
         S_START: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_st.done) begin
               steps_left_in = n_ff;
               state_in      = S_MUL;
            end
         end
         S_MUL: begin
            state_in = S_ACC;
         end
         S_ACC: begin
            intensity_in  = mac_nxt;
            steps_left_in = steps_left_ff - 1'b1;
            state_in      = (steps_left_ff == STEP_W'(1)) ? S_DONE : S_MUL;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_int_in   = intensity_ff;
               rsp_end_in   = last_ff;
               if (last_ff) begin
                  intensity_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      sat_in  = sat_ff;
      spud_in = spud_ff;
      if (csr.valid) begin
         unique case (csr.index)
            REG_SATURATE_DEPTH: sat_in  = csr.data[INT_W-1:0];
            REG_STEPS_PER_UNIT: spud_in = csr.data[SPUD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         intensity_ff <= '0;
         sat_ff       <= SATURATE_RESET;
         spud_ff      <= STEPS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         intensity_ff <= intensity_in;
         sat_ff       <= sat_in;
         spud_ff      <= spud_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_int_ff    <= rsp_int_in;
      rsp_end_ff    <= rsp_end_in;
      depth_ff      <= depth_in;
      source_ff     <= source_in;
      last_ff       <= last_in;
      n_ff          <= n_in;
      steps_left_ff <= steps_left_in;
   end

   assign req.ready      = state_ff == S_IDLE;
   assign csr.ready      = 1'b1;
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.intensity  = rsp_int_ff;
   assign rsp.column_end = rsp_end_ff;

   `RTC_ASSERT(a_div_done_in_div, clock, reset, div_st.done |-> state_ff == S_DIV)
   `RTC_ASSERT(a_steps_in_range, clock, reset, (state_ff == S_MUL || state_ff == S_ACC) |-> (steps_left_ff != '0 && steps_left_ff <= STEP_W'(MAX_STEPS)))
   `RTC_ASSERT(a_acc_after_mul, clock, reset, state_ff == S_ACC |-> $past(state_ff) == S_MUL)
   `RTC_NEVER(a_n_zero_in_div, clock, reset, state_ff == S_DIV && n_ff == '0)
   `RTC_NEVER(a_busy_outside_div, clock, reset, div_st.busy && state_ff != S_DIV)

endmodule
